// File: rtl/core/deq_pkg.sv
// ----------------------------------------------------------------------------
// deq_pkg
// Shared types and constants of the double-ended queue core.
// ----------------------------------------------------------------------------
package deq_pkg;

    localparam int DEPTH  = 64;
    localparam int DATA_W = 32;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);

    // Operation codes of the action field.
    localparam logic [1:0] ACT_PUSH_TOP    = 2'd0;
    localparam logic [1:0] ACT_PUSH_BOTTOM = 2'd1;
    localparam logic [1:0] ACT_POP_TOP     = 2'd2;
    localparam logic [1:0] ACT_POP_BOTTOM  = 2'd3;

    // Result status codes.
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_EMPTY = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic exec;     // execute the item accepted at this edge
        logic capture;  // load the RAM read data into the result register
    } deq_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;  // result register is empty or is taken this cycle
        logic pop_hit;   // offered item is a pop on a non-empty deque
    } deq_sts_t;

endpackage

// File: rtl/core/deq_ram.sv
// ----------------------------------------------------------------------------
// deq_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module deq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/core/deq_ctrl.sv
// ----------------------------------------------------------------------------
// deq_ctrl
// Controller: accepts items and sequences the RAM read of a successful pop.
// ----------------------------------------------------------------------------
module deq_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  deq_pkg::deq_sts_t sts,
    output deq_pkg::deq_cmd_t cmd
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_READ = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign s_ready = (state_reg == S_IDLE) && sts.out_free;
    assign accept  = s_valid && s_ready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (accept && sts.pop_hit) begin
                    state_next = S_READ;
                end
            end
            S_READ: begin
                state_next = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign cmd.exec    = accept;
    assign cmd.capture = (state_reg == S_READ);

endmodule

// File: rtl/core/deq_dp.sv
// ----------------------------------------------------------------------------
// deq_dp
// Datapath: ring indices, fill count, entry RAM and the result register.
// ----------------------------------------------------------------------------
module deq_dp (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  deq_pkg::deq_cmd_t                   cmd,
    output deq_pkg::deq_sts_t                   sts,
    input  logic [1:0]                          s_action,
    input  logic signed [deq_pkg::DATA_W-1:0]   s_push_value,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [deq_pkg::DATA_W-1:0]   m_popped_value,
    output logic [1:0]                          m_status
);

    localparam logic [deq_pkg::IDX_W-1:0] IdxLast = deq_pkg::IDX_W'(deq_pkg::DEPTH - 1);
    localparam logic [deq_pkg::CNT_W-1:0] CntFull = deq_pkg::CNT_W'(deq_pkg::DEPTH);
    localparam logic [deq_pkg::CNT_W-1:0] CntOne  = deq_pkg::CNT_W'(1);

    logic [deq_pkg::IDX_W-1:0]  top_reg, top_next;
    logic [deq_pkg::IDX_W-1:0]  bottom_reg, bottom_next;
    logic [deq_pkg::CNT_W-1:0]  count_reg, count_next;
    logic                       valid_reg, valid_next;
    logic [deq_pkg::DATA_W-1:0] value_reg, value_next;
    logic [1:0]                 status_reg, status_next;

    logic                       is_pop;
    logic                       empty;
    logic                       full;
    logic [deq_pkg::IDX_W-1:0]  top_up, top_down, bottom_up, bottom_down;

    logic                       ram_we;
    logic [deq_pkg::IDX_W-1:0]  ram_waddr;
    logic                       ram_re;
    logic [deq_pkg::IDX_W-1:0]  ram_raddr;
    logic [deq_pkg::DATA_W-1:0] ram_rdata;

    assign is_pop = (s_action == deq_pkg::ACT_POP_TOP) || (s_action == deq_pkg::ACT_POP_BOTTOM);
    assign empty  = (count_reg == '0);
    assign full   = (count_reg == CntFull);

    assign top_up      = (top_reg == IdxLast) ? '0 : top_reg + 1'b1;
    assign top_down    = (top_reg == '0) ? IdxLast : top_reg - 1'b1;
    assign bottom_up   = (bottom_reg == IdxLast) ? '0 : bottom_reg + 1'b1;
    assign bottom_down = (bottom_reg == '0) ? IdxLast : bottom_reg - 1'b1;

    assign sts.out_free = !valid_reg || m_ready;
    assign sts.pop_hit  = is_pop && !empty;

    always_comb begin
        top_next    = top_reg;
        bottom_next = bottom_reg;
        count_next  = count_reg;
        valid_next  = valid_reg && !m_ready;
        value_next  = value_reg;
        status_next = status_reg;
        ram_we      = 1'b0;
        ram_waddr   = top_reg;
        ram_re      = 1'b0;
        ram_raddr   = top_reg;

        if (cmd.exec) begin
            if (!is_pop) begin
                valid_next = 1'b1;
                value_next = '0;
                if (full) begin
                    status_next = deq_pkg::STAT_FULL;
                end else begin
                    status_next = deq_pkg::STAT_OK;
                    ram_we      = 1'b1;
                    count_next  = count_reg + 1'b1;
                    if (empty) begin
                        bottom_next = top_reg;
                        ram_waddr   = top_reg;
                    end else if (s_action == deq_pkg::ACT_PUSH_TOP) begin
                        top_next  = top_up;
                        ram_waddr = top_up;
                    end else begin
                        bottom_next = bottom_down;
                        ram_waddr   = bottom_down;
                    end
                end
            end else if (empty) begin
                valid_next  = 1'b1;
                value_next  = '0;
                status_next = deq_pkg::STAT_EMPTY;
            end else begin
                // The result follows once the registered RAM read returns.
                ram_re     = 1'b1;
                count_next = count_reg - 1'b1;
                if (s_action == deq_pkg::ACT_POP_TOP) begin
                    ram_raddr = top_reg;
                    if (count_reg != CntOne) begin
                        top_next = top_down;
                    end
                end else begin
                    ram_raddr = bottom_reg;
                    if (count_reg != CntOne) begin
                        bottom_next = bottom_up;
                    end
                end
            end
        end else if (cmd.capture) begin
            valid_next  = 1'b1;
            value_next  = ram_rdata;
            status_next = deq_pkg::STAT_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            top_reg    <= '0;
            bottom_reg <= '0;
            count_reg  <= '0;
            valid_reg  <= 1'b0;
        end else begin
            top_reg    <= top_next;
            bottom_reg <= bottom_next;
            count_reg  <= count_next;
            valid_reg  <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg  <= value_next;
        status_reg <= status_next;
    end

    deq_ram #(
        .WIDTH (deq_pkg::DATA_W),
        .DEPTH (deq_pkg::DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (s_push_value),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign m_valid        = valid_reg;
    assign m_popped_value = value_reg;
    assign m_status       = status_reg;

endmodule

// File: rtl/core/double_ended_queue_core.sv
// ----------------------------------------------------------------------------
// double_ended_queue_core
// Double-ended queue of signed 32-bit words held in a 64-entry ring buffer.
// ----------------------------------------------------------------------------
// Each input item pushes a word on the top or the bottom, or pops a word from
// the top or the bottom, and returns exactly one result item carrying the
// popped word and a status (ok, pop on empty, push on full dropped). Pushes,
// failed pushes and pops on an empty deque let the next item be accepted in
// the cycle after, provided the result register is empty or is being taken.
// A successful pop holds off the next item while its word comes out of the
// entry RAM through its registered read port and into the result register.
// The entry RAM needs no clearing after reset, so the block accepts items
// from the first cycle after reset is released.
// ----------------------------------------------------------------------------
module double_ended_queue_core (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [1:0]                        s_action,
    input  logic signed [deq_pkg::DATA_W-1:0] s_push_value,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [deq_pkg::DATA_W-1:0] m_popped_value,
    output logic [1:0]                        m_status
);

    deq_pkg::deq_cmd_t cmd;
    deq_pkg::deq_sts_t sts;
    logic              accept;

    // The controller decides when an item is accepted and when a RAM read
    // result is ready to be captured.
    deq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // The datapath keeps the ring indices, the count, the RAM and the result.
    deq_dp u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .sts            (sts),
        .s_action       (s_action),
        .s_push_value   (s_push_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_popped_value (m_popped_value),
        .m_status       (m_status)
    );

    assign accept = s_valid && s_ready;

    // When the RAM data is captured, the result register must already be free.
    a_capture_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.capture |-> !m_valid)
        else $error("RAM read captured while a result is still held");

    // A successful pop is followed by the capture of its RAM read.
    a_pop_capture: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && sts.pop_hit) |=> cmd.capture)
        else $error("successful pop not followed by a capture");

    // Every other item shows its result in the next cycle.
    a_direct_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && !sts.pop_hit) |=> (m_valid && !cmd.capture))
        else $error("item without RAM read gave no result");

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the double-ended queue core.
// ----------------------------------------------------------------------------
// A short table of directed items covers both empty pops, both push ends, the
// extreme words and the last-word pop. A long random run follows. It is built
// from fill runs into the full condition, drain runs into the empty
// condition, mixed runs and noise. Each accepted item goes through a local
// model of the ring. The model's result is queued and compared field by field
// with the result items as they leave the block. Both sides idle in bursts,
// and once the receiver stalls long enough that the block backs up into its
// input.
// ----------------------------------------------------------------------------
module tb;

    localparam int RANDOM_ITEMS   = 1330;
    localparam int CALM_ITEMS     = 150;   // tail of the run without idling
    localparam int HOLD_CYCLES    = 250;   // long receiver stall
    localparam int WATCHDOG_LIMIT = 2000;  // cycles with no item moving
    localparam int DRAIN_CYCLES   = 20;
    localparam int NUM_DIRECTED   = 24;

    typedef struct packed {
        logic [1:0]  act;
        logic [31:0] word;
        logic        fixed;     // expectation typed in below, not predicted
        logic [31:0] want_pop;
        logic [1:0]  want_st;
    } stim_row_t;

    typedef struct packed {
        logic [31:0] popped;
        logic [1:0]  status;
    } deque_result_t;

    logic                              aclk;
    logic                              aresetn;
    logic                              s_valid;
    logic                              s_ready;
    logic [1:0]                        s_action;
    logic signed [deq_pkg::DATA_W-1:0] s_push_value;
    logic                              m_valid;
    logic                              m_ready;
    logic signed [deq_pkg::DATA_W-1:0] m_popped_value;
    logic [1:0]                        m_status;

    // Typed expectation that travels alongside the item being offered.
    logic                     cur_fixed;
    logic [31:0]              cur_want_pop;
    logic [1:0]               cur_want_st;

    // The bench's own copy of the ring.
    logic [31:0]              ring_words [deq_pkg::DEPTH];
    int                       top_at;
    int                       bottom_at;
    int                       held_count;

    deque_result_t            pending_results [$];
    stim_row_t                directed_rows [NUM_DIRECTED];
    int                       mismatch_count;
    int                       idle_cycles;
    int                       items_sent;
    bit                       calm;
    bit                       gaps_on;
    bit                       hold_request;

    double_ended_queue_core DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_action       (s_action),
        .s_push_value   (s_push_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_popped_value (m_popped_value),
        .m_status       (m_status)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Applies one item to the local ring and returns the result it gives.
    // The top climbs the ring on a push, and the bottom falls. The first word
    // into an empty deque lands under the top index, and both indices meet
    // there. The last word out leaves both indices on the freed entry.
    function automatic deque_result_t deque_apply(input logic [1:0] act,
                                                  input logic [31:0] word);
        deque_result_t r;
        r.popped = '0;
        r.status = deq_pkg::STAT_OK;
        case (act)
            deq_pkg::ACT_PUSH_TOP, deq_pkg::ACT_PUSH_BOTTOM: begin
                if (held_count >= deq_pkg::DEPTH) begin
                    r.status = deq_pkg::STAT_FULL;
                end else begin
                    if (held_count == 0) begin
                        bottom_at = top_at;
                    end else if (act == deq_pkg::ACT_PUSH_TOP) begin
                        top_at = (top_at + 1) % deq_pkg::DEPTH;
                    end else begin
                        bottom_at = (bottom_at + deq_pkg::DEPTH - 1) % deq_pkg::DEPTH;
                    end
                    if (act == deq_pkg::ACT_PUSH_TOP) begin
                        ring_words[top_at] = word;
                    end else begin
                        ring_words[bottom_at] = word;
                    end
                    held_count++;
                end
            end
            default: begin
                if (held_count == 0) begin
                    r.status = deq_pkg::STAT_EMPTY;
                end else begin
                    r.popped = (act == deq_pkg::ACT_POP_TOP) ? ring_words[top_at]
                                                             : ring_words[bottom_at];
                    held_count--;
                    if (held_count != 0) begin
                        if (act == deq_pkg::ACT_POP_TOP) begin
                            top_at = (top_at + deq_pkg::DEPTH - 1) % deq_pkg::DEPTH;
                        end else begin
                            bottom_at = (bottom_at + 1) % deq_pkg::DEPTH;
                        end
                    end
                end
            end
        endcase
        return r;
    endfunction

    // Random word with the extremes and the all-zero and all-one patterns
    // showing up often.
    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 9))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h7FFF_FFFF;
            3:       return 32'h8000_0000;
            default: return $urandom;
        endcase
    endfunction

    // Offers one item and returns at the falling edge after it is accepted.
    // A gap is opened before the item only while valid is free to drop,
    // that is, between items and never while one is waiting.
    task automatic send_item(input logic [1:0] act, input logic [31:0] word,
                             input logic fixed, input logic [31:0] want_pop,
                             input logic [1:0] want_st);
        if (gaps_on && !calm && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge aclk);
        end
        s_valid      <= 1'b1;
        s_action     <= act;
        s_push_value <= word;
        cur_fixed    <= fixed;
        cur_want_pop <= want_pop;
        cur_want_st  <= want_st;
        do @(posedge aclk); while (!(s_valid && s_ready));
        items_sent++;
        @(negedge aclk);
    endtask

    task automatic send_random(input logic [1:0] act);
        send_item(act, pick_word(), 1'b0, '0, deq_pkg::STAT_OK);
    endtask

    function automatic logic [1:0] random_push();
        return $urandom_range(0, 1) ? deq_pkg::ACT_PUSH_TOP : deq_pkg::ACT_PUSH_BOTTOM;
    endfunction

    function automatic logic [1:0] random_pop();
        return $urandom_range(0, 1) ? deq_pkg::ACT_POP_TOP : deq_pkg::ACT_POP_BOTTOM;
    endfunction

    // Receiver. It is mostly ready, with short stalls. Once, on request, it
    // stalls long enough that the result side backs up and the block stops
    // taking items while the sender keeps offering.
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_request) begin
                hold_request = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                m_ready <= 1'b1;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(negedge aclk);
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Everything is sampled at the rising edge in this one block. The result
    // leaving is checked first, then the item entering is predicted. An item
    // can never produce its result at the same edge at which it is taken,
    // so this order holds for any latency.
    always @(posedge aclk) begin
        deque_result_t want;
        deque_result_t got;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                got.popped = m_popped_value;
                got.status = m_status;
                if (pending_results.size() == 0) begin
                    $error("unexpected result item: popped_value %0d status %0d",
                           $signed(got.popped), got.status);
                    mismatch_count++;
                end else begin
                    want = pending_results.pop_front();
                    if (got.popped !== want.popped) begin
                        $error("popped_value: expected %0d, actual %0d",
                               $signed(want.popped), $signed(got.popped));
                        mismatch_count++;
                    end
                    if (got.status !== want.status) begin
                        $error("status: expected %0d, actual %0d",
                               want.status, got.status);
                        mismatch_count++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                // The model always runs so that its ring stays in step. A
                // typed row then replaces its answer with the one from the table.
                want = deque_apply(s_action, s_push_value);
                if (cur_fixed) begin
                    want.popped = cur_want_pop;
                    want.status = cur_want_st;
                end
                pending_results.push_back(want);
            end
            // Watchdog: a run in which no item moves for this long has hung.
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("** double_ended_queue_core: FAILED **");
                $finish;
            end
        end
    end

    initial begin
        int phase;
        int run_len;
        int bias;
        bit first_phase;

        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_action       = deq_pkg::ACT_POP_TOP;
        s_push_value   = '0;
        cur_fixed      = 1'b0;
        cur_want_pop   = '0;
        cur_want_st    = deq_pkg::STAT_OK;
        top_at         = 0;
        bottom_at      = 0;
        held_count     = 0;
        mismatch_count = 0;
        idle_cycles    = 0;
        items_sent     = 0;
        calm           = 1'b0;
        gaps_on        = 1'b1;
        hold_request   = 1'b0;
        first_phase    = 1'b1;

        // Directed items. The rows with a typed result are those readable at
        // a glance: the empty pops and the extreme words pushed and coming
        // straight back. The rest is left to the model.
        directed_rows = '{
            '{deq_pkg::ACT_POP_TOP,     32'h1234_5678, 1'b1, 32'h0000_0000, deq_pkg::STAT_EMPTY},
            '{deq_pkg::ACT_POP_BOTTOM,  32'hFFFF_FFFF, 1'b1, 32'h0000_0000, deq_pkg::STAT_EMPTY},
            '{deq_pkg::ACT_PUSH_TOP,    32'h7FFF_FFFF, 1'b1, 32'h0000_0000, deq_pkg::STAT_OK},
            '{deq_pkg::ACT_POP_TOP,     32'h0000_0000, 1'b1, 32'h7FFF_FFFF, deq_pkg::STAT_OK},
            '{deq_pkg::ACT_POP_TOP,     32'hA5A5_A5A5, 1'b1, 32'h0000_0000, deq_pkg::STAT_EMPTY},
            '{deq_pkg::ACT_PUSH_BOTTOM, 32'h8000_0000, 1'b1, 32'h0000_0000, deq_pkg::STAT_OK},
            '{deq_pkg::ACT_POP_BOTTOM,  32'h0000_0000, 1'b1, 32'h8000_0000, deq_pkg::STAT_OK},
            '{deq_pkg::ACT_POP_BOTTOM,  32'h0000_0000, 1'b1, 32'h0000_0000, deq_pkg::STAT_EMPTY},
            '{deq_pkg::ACT_PUSH_TOP,    32'h0000_0001, 1'b0, 32'h0000_0000, deq_pkg::STAT_OK},
            '{deq_pkg::ACT_PUSH_TOP,    32'h0000_0002, 1'b0, 32'h0000_0000, deq_pkg::STAT_OK},
            '{deq_pkg::ACT_PUSH_BOTTOM, 32'hFFFF_FFFF, 1'b0, 32'h0000_0000, deq_pkg::STAT_OK},
            '{deq_pkg::ACT_PUSH_BOTTOM, 32'hFFFF_FFFE, 1'b0, 32'h0000_0000, deq_pkg::STAT_OK},
            '{deq_pkg::ACT_POP_TOP,     32'h5A5A_5A5A, 1'b0, 32'h0000_0000, deq_pkg::STAT_OK},
            '{deq_pkg::ACT_POP_BOTTOM,  32'h0000_0000, 1'b0, 32'h0000_0000, deq_pkg::STAT_OK},
            '{deq_pkg::ACT_POP_BOTTOM,  32'h0000_0000, 1'b0, 32'h0000_0000, deq_pkg::STAT_OK},
            '{deq_pkg::ACT_POP_TOP,     32'h0000_0000, 1'b0, 32'h0000_0000, deq_pkg::STAT_OK},
            '{deq_pkg::ACT_POP_TOP,     32'h0000_0000, 1'b1, 32'h0000_0000, deq_pkg::STAT_EMPTY},
            '{deq_pkg::ACT_PUSH_BOTTOM, 32'h0000_0000, 1'b0, 32'h0000_0000, deq_pkg::STAT_OK},
            '{deq_pkg::ACT_POP_TOP,     32'hFFFF_FFFF, 1'b0, 32'h0000_0000, deq_pkg::STAT_OK},
            '{deq_pkg::ACT_PUSH_TOP,    32'h5555_5555, 1'b0, 32'h0000_0000, deq_pkg::STAT_OK},
            '{deq_pkg::ACT_PUSH_TOP,    32'hAAAA_AAAA, 1'b0, 32'h0000_0000, deq_pkg::STAT_OK},
            '{deq_pkg::ACT_POP_BOTTOM,  32'h0000_0000, 1'b0, 32'h0000_0000, deq_pkg::STAT_OK},
            '{deq_pkg::ACT_POP_BOTTOM,  32'h0000_0000, 1'b0, 32'h0000_0000, deq_pkg::STAT_OK},
            '{deq_pkg::ACT_POP_BOTTOM,  32'h0000_0000, 1'b1, 32'h0000_0000, deq_pkg::STAT_EMPTY}
        };

        // Reset is held from the start and released at a falling edge.
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        for (int i = 0; i < NUM_DIRECTED; i++) begin
            send_item(directed_rows[i].act, directed_rows[i].word,
                      directed_rows[i].fixed, directed_rows[i].want_pop,
                      directed_rows[i].want_st);
        end

        // Random part. It is built from runs. A fill run ends with a few
        // pushes on the full deque, and a drain run ends with a few pops on
        // the empty one. The ring wraps through both indices many times over.
        // The first run is a fill with the long receiver stall laid over it.
        items_sent = 0;
        while (items_sent < RANDOM_ITEMS) begin
            calm    = (items_sent >= RANDOM_ITEMS - CALM_ITEMS);
            gaps_on = ($urandom_range(0, 3) != 0);
            phase   = first_phase ? 0 : $urandom_range(0, 9);
            if (first_phase) begin
                hold_request = 1'b1;
                first_phase  = 1'b0;
            end
            if (phase <= 2) begin
                while (held_count < deq_pkg::DEPTH) send_random(random_push());
                repeat ($urandom_range(1, 3)) send_random(random_push());
            end else if (phase <= 5) begin
                while (held_count > 0) send_random(random_pop());
                repeat ($urandom_range(1, 3)) send_random(random_pop());
            end else if (phase <= 8) begin
                run_len = $urandom_range(20, 60);
                bias    = $urandom_range(30, 70);
                repeat (run_len) begin
                    if ($urandom_range(0, 99) < bias) begin
                        send_random(random_push());
                    end else begin
                        send_random(random_pop());
                    end
                end
            end else begin
                run_len = $urandom_range(5, 20);
                repeat (run_len) send_random(2'($urandom_range(0, 3)));
            end
        end
        s_valid <= 1'b0;

        // Let every outstanding result item come back, then watch a little
        // longer for anything extra.
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatch_count == 0) begin
            $display("** double_ended_queue_core: PASSED **");
        end else begin
            $display("** double_ended_queue_core: FAILED **");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/deq_pkg.sv
rtl/core/deq_ram.sv
rtl/core/deq_ctrl.sv
rtl/core/deq_dp.sv
rtl/core/double_ended_queue_core.sv
bench/tb.sv
